>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, disabled while the active-low reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on every rising clock edge.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on every rising clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/wmw_pkg.sv
package wmw_pkg;

  localparam int WINDOW_LEN = 7;

  localparam int SPEED_W = 16;
  localparam int MAG_W   = SPEED_W + 1;
  localparam int LIMIT_W = 15;
  localparam int NEED_W  = 5;
  localparam int CFG_W   = 15;
  localparam int CFG_IDX_W = 2;

  localparam int CNT_W   = $clog2(WINDOW_LEN + 1);
  localparam int CMP_W   = (CNT_W > NEED_W) ? CNT_W : NEED_W;
  localparam int CELL_SCORE_W = 4;
  localparam int SCORE_W = $clog2(5 * WINDOW_LEN + 1) + 1;
  localparam int OUT_SCORE_W = 8;
  localparam int SAT_W   = (SCORE_W > OUT_SCORE_W) ? SCORE_W : OUT_SCORE_W;

  localparam logic signed [CELL_SCORE_W-1:0] SCORE_EQUAL = 4'sd5;
  localparam logic signed [CELL_SCORE_W-1:0] SCORE_OPPOSITE = 4'sd3;
  localparam logic signed [CELL_SCORE_W-1:0] SCORE_IMBALANCE = 4'sd1;

  localparam logic [2:0] STATUS_STOP  = 3'd0;
  localparam logic [2:0] STATUS_STILL = 3'd1;
  localparam logic [2:0] STATUS_AHEAD = 3'd2;
  localparam logic [2:0] STATUS_BACK  = 3'd3;
  localparam logic [2:0] STATUS_MOVE  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_STOP_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_COUNT = 2'd2;

  localparam logic [LIMIT_W-1:0] STOP_LIMIT_RESET = 15'd5;
  localparam logic [NEED_W-1:0]  STOP_COUNT_RESET = 5'd4;
  localparam logic [NEED_W-1:0]  TURN_COUNT_RESET = 5'd4;

  typedef struct packed {
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
  } wmw_in_t;

  typedef struct packed {
    logic [2:0]                    motion_status;
    logic signed [OUT_SCORE_W-1:0] direction_score;
    logic                          score_valid;
  } wmw_out_t;

  typedef struct packed {
    logic                           stop;
    logic                           same;
    logic                           still;
    logic                           ahead;
    logic                           back;
    logic signed [CELL_SCORE_W-1:0] score;
  } wmw_flags_t;

  typedef struct packed {
    logic [CNT_W-1:0]          stops;
    logic [CNT_W-1:0]          same;
    logic [CNT_W-1:0]          still;
    logic [CNT_W-1:0]          ahead;
    logic [CNT_W-1:0]          back;
    logic signed [SCORE_W-1:0] score;
  } wmw_tally_t;

endpackage

>>> rtl/core/wmw_cell.sv
module wmw_cell
  import wmw_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  wmw_in_t            sample_i,
  input  logic [LIMIT_W-1:0] stop_limit_i,
  output wmw_in_t            sample_o,
  output wmw_flags_t         flags_o
);

  wmw_in_t sample_q;

  logic [MAG_W-1:0] al;
  logic [MAG_W-1:0] ar;
  logic             lp, ln, lz, rp, rn, rz;
  logic             eq;
  logic             l_gt;
  logic [MAG_W-1:0] lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (shift_i) begin
      sample_q <= sample_i;
    end
  end

  assign sample_o = sample_q;

  always_comb begin
    lz   = (sample_q.left_speed == '0);
    rz   = (sample_q.right_speed == '0);
    ln   = sample_q.left_speed[SPEED_W-1];
    rn   = sample_q.right_speed[SPEED_W-1];
    lp   = !ln && !lz;
    rp   = !rn && !rz;
    al   = ln ? (MAG_W'(0) - MAG_W'(sample_q.left_speed))
              : MAG_W'(sample_q.left_speed);
    ar   = rn ? (MAG_W'(0) - MAG_W'(sample_q.right_speed))
              : MAG_W'(sample_q.right_speed);
    eq   = (al == ar);
    l_gt = (al > ar);
    lim  = MAG_W'(stop_limit_i);

    flags_o       = '0;
    flags_o.stop  = !lz && (al < lim) && !rz && (ar < lim);

    if ((lp && rp) || (ln && rn)) begin
      flags_o.same = 1'b1;
      if (eq) begin
        flags_o.still = 1'b1;
      end else if (lp == l_gt) begin
        flags_o.ahead = 1'b1;
        flags_o.score = SCORE_IMBALANCE;
      end else begin
        flags_o.back  = 1'b1;
        flags_o.score = -SCORE_IMBALANCE;
      end
    end else if (lp && rn) begin
      flags_o.score = eq ? SCORE_EQUAL : SCORE_OPPOSITE;
    end else if (ln && rp) begin
      flags_o.score = eq ? -SCORE_EQUAL : -SCORE_OPPOSITE;
    end else if ((lz && rn) || (lp && rz)) begin
      flags_o.score = SCORE_OPPOSITE;
    end else if ((lz && rp) || (ln && rz)) begin
      flags_o.score = -SCORE_OPPOSITE;
    end
  end

endmodule

>>> rtl/core/wmw_tally.sv
module wmw_tally
  import wmw_pkg::*;
(
  input  logic       clk_i,
  input  logic       load_i,
  input  wmw_flags_t flags_i [WINDOW_LEN],
  output wmw_tally_t tally_o
);

  wmw_tally_t sum_d;
  wmw_tally_t tally_q;

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < WINDOW_LEN; k++) begin
      sum_d.stops = sum_d.stops + CNT_W'(flags_i[k].stop);
      sum_d.same  = sum_d.same  + CNT_W'(flags_i[k].same);
      sum_d.still = sum_d.still + CNT_W'(flags_i[k].still);
      sum_d.ahead = sum_d.ahead + CNT_W'(flags_i[k].ahead);
      sum_d.back  = sum_d.back  + CNT_W'(flags_i[k].back);
      sum_d.score = sum_d.score + SCORE_W'(flags_i[k].score);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tally_q <= sum_d;
    end
  end

  assign tally_o = tally_q;

endmodule

>>> rtl/core/wheel_motion_window_classifier.sv
// An accepted request shifts the sample chain, its tally is registered, and the result
// is moved to the result register once that register is free. No new request is
// accepted until the tally of the previous one has moved to the result register.
// The result register lets the next request in while a result waits.
// Reset clears the window to zero and loads the default configuration.
`include "assert_macros.svh"

module wheel_motion_window_classifier
  import wmw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  wmw_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output wmw_out_t             out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic [LIMIT_W-1:0] stop_limit_q;
  logic [NEED_W-1:0]  stop_need_q;
  logic [NEED_W-1:0]  turn_need_q;

  logic       in_fire;
  logic       pend_q;
  logic       tally_valid_q;
  logic       out_valid_q;
  logic       out_free;
  logic       move_out;
  wmw_out_t   out_q;
  wmw_out_t   result_d;

  wmw_in_t    chain   [WINDOW_LEN+1];
  wmw_flags_t flags   [WINDOW_LEN];
  wmw_tally_t tally;

  logic signed [SAT_W-1:0] score_ext;
  logic [CMP_W-1:0]        stop_need;
  logic [CMP_W-1:0]        turn_need;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_limit_q <= STOP_LIMIT_RESET;
      stop_need_q  <= STOP_COUNT_RESET;
      turn_need_q  <= TURN_COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STOP_LIMIT: stop_limit_q <= LIMIT_W'(cfg_data_i);
        CFG_STOP_COUNT: stop_need_q  <= NEED_W'(cfg_data_i);
        CFG_TURN_COUNT: turn_need_q  <= NEED_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign in_ready_o = !pend_q && !tally_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign chain[WINDOW_LEN] = in_data_i;

  for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_cell
    wmw_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .shift_i      (in_fire),
      .sample_i     (chain[k+1]),
      .stop_limit_i (stop_limit_q),
      .sample_o     (chain[k]),
      .flags_o      (flags[k])
    );
  end

  wmw_tally u_tally (
    .clk_i   (clk_i),
    .load_i  (pend_q),
    .flags_i (flags),
    .tally_o (tally)
  );

  always_comb begin
    stop_need = CMP_W'(stop_need_q);
    turn_need = CMP_W'(turn_need_q);
    score_ext = SAT_W'(tally.score);

    result_d = '0;
    if (CMP_W'(tally.stops) >= stop_need) begin
      result_d.motion_status = STATUS_STOP;
    end else if (CMP_W'(tally.same) >= turn_need) begin
      if (CMP_W'(tally.still) >= turn_need) begin
        result_d.motion_status = STATUS_STILL;
      end else if (CMP_W'(tally.ahead) >= turn_need) begin
        result_d.motion_status = STATUS_AHEAD;
      end else if (CMP_W'(tally.back) >= turn_need) begin
        result_d.motion_status = STATUS_BACK;
      end else begin
        result_d.motion_status = STATUS_MOVE;
      end
    end else begin
      result_d.motion_status = STATUS_MOVE;
    end

    move_out = (result_d.motion_status == STATUS_MOVE);
    if (move_out) begin
      result_d.score_valid = 1'b1;
      if (score_ext > SAT_W'(127)) begin
        result_d.direction_score = 8'sd127;
      end else if (score_ext < SAT_W'(-128)) begin
        result_d.direction_score = -8'sd128;
      end else begin
        result_d.direction_score = OUT_SCORE_W'(score_ext);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q        <= 1'b0;
      tally_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      pend_q <= in_fire;
      if (pend_q) begin
        tally_valid_q <= 1'b1;
      end else if (tally_valid_q && out_free) begin
        tally_valid_q <= 1'b0;
      end
      if (tally_valid_q && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tally_valid_q && out_free) begin
      out_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_NEXT(a_accept_sets_pend, clk_i, rst_ni, in_fire, pend_q && !in_ready_o, "accepted request did not reach the tally stage")
  `ASSERT_IMPL(a_single_item, clk_i, rst_ni, pend_q, !tally_valid_q, "two requests inside the window stages")
  `ASSERT_NEXT(a_tally_held, clk_i, rst_ni, tally_valid_q && out_valid_q && !out_ready_i, tally_valid_q, "tally dropped while the result register was full")
  `ASSERT_IMPL(a_score_only_moving, clk_i, rst_ni, out_valid_q, out_q.score_valid == (out_q.motion_status == STATUS_MOVE), "score valid does not match moving status")
  `ASSERT_IMPL(a_score_zero, clk_i, rst_ni, out_valid_q && !out_q.score_valid, out_q.direction_score == '0, "score not cleared outside moving status")

endmodule
